// ===== hw/rtl/counting_semaphore_fifo_assert.svh =====
// Assertion macros used by the checker file.
`ifndef COUNTING_SEMAPHORE_FIFO_ASSERT_SVH
`define COUNTING_SEMAPHORE_FIFO_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define CSF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csf assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define CSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csf assertion failed");

`endif

// ===== hw/rtl/csf_pkg.sv =====
`timescale 1ns / 1ps

package csf_pkg;

    typedef enum logic [1:0] {
        CMD_WAIT   = 2'd0,
        CMD_SIGNAL = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_INIT   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_GRANTED = 3'd0,
        STS_BLOCKED = 3'd1,
        STS_WOKEN   = 3'd2,
        STS_FLUSHED = 3'd3,
        STS_RAISED  = 3'd4,
        STS_FULL    = 3'd5,
        STS_DONE    = 3'd6
    } t_status;

    typedef enum logic {
        BK_IDLE  = 1'b0,
        BK_FLUSH = 1'b1
    } t_back_state;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        t_cmd        command;
        logic [7:0]  requester_id;
        logic [15:0] init_count;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  woken_id;
        logic [15:0] current_count;
        logic        last;
    } t_out_item;

    // Decoded command handed from front to back.
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  id;
        logic [15:0] init_count;
    } t_cmd_item;

endpackage

// ===== hw/rtl/csf_front.sv =====
`timescale 1ns / 1ps

module csf_front #(
    parameter int ID_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  csf_pkg::t_in_item   i_in_data,
    output logic                o_cmd_valid,
    input  logic                i_cmd_pop,
    output csf_pkg::t_cmd_item  o_cmd
);
    import csf_pkg::*;

    t_cmd_item          r_slot [2];
    logic               r_wr_ptr, n_wr_ptr;
    logic               r_rd_ptr, n_rd_ptr;
    logic [1:0]         r_fill, n_fill;
    logic [15:0]        id_ext;
    logic [ID_BITS-1:0] id_keep;
    t_cmd_item          decoded;
    logic               push;
    logic               pop;

    assign id_ext  = {8'd0, i_in_data.requester_id};
    assign id_keep = id_ext[ID_BITS-1:0];

    always_comb begin
        decoded.cmd        = i_in_data.command;
        decoded.id         = 8'(16'(id_keep));
        decoded.init_count = i_in_data.init_count;
    end

    assign o_in_ready  = (r_fill != 2'd2);
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= decoded;
        end
    end

endmodule

// ===== hw/rtl/csf_back.sv =====
`timescale 1ns / 1ps

module csf_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    input  csf_pkg::t_cmd_item  i_cmd,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csf_pkg::t_out_item  o_out_data
);
    import csf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    t_back_state        r_state, n_state;
    logic [15:0]        r_count, n_count;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [ID_BITS-1:0] r_queue_mem [QUEUE_DEPTH];
    logic [ID_BITS-1:0] r_rd_data;
    logic               mem_we;
    logic [ID_BITS-1:0] mem_wdata;
    logic [15:0]        id_ext;

    logic               out_free;
    logic               take;
    logic               full;
    logic               emit;
    t_status            res_status;
    logic [7:0]         res_id;
    logic               res_last;
    logic [7:0]         head_id;
    logic [PTR_W-1:0]   head_inc;
    logic [PTR_W-1:0]   tail_inc;

    assign out_free  = !r_out_valid || i_out_ready;
    assign take      = i_cmd_valid && (r_state == BK_IDLE) && out_free;
    assign o_cmd_pop = take;
    assign full      = (r_occ == OCC_W'(QUEUE_DEPTH));
    assign id_ext    = {8'd0, i_cmd.id};
    assign mem_wdata = id_ext[ID_BITS-1:0];
    assign head_id   = 8'(16'(r_rd_data));
    assign head_inc  = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc  = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (take && i_cmd.cmd == CMD_FLUSH) begin
                    n_state = BK_FLUSH;
                end
            end
            BK_FLUSH: begin
                if (out_free && r_occ == '0) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        n_count    = r_count;
        n_head     = r_head;
        n_tail     = r_tail;
        n_occ      = r_occ;
        mem_we     = 1'b0;
        emit       = 1'b0;
        res_status = STS_DONE;
        res_id     = 8'd0;
        res_last   = 1'b1;
        unique case (r_state)
            BK_IDLE: begin
                if (take) begin
                    unique case (i_cmd.cmd)
                        CMD_WAIT: begin
                            emit = 1'b1;
                            if (r_count != 16'd0) begin
                                n_count    = r_count - 16'd1;
                                res_status = STS_GRANTED;
                            end else if (!full) begin
                                mem_we     = 1'b1;
                                n_tail     = tail_inc;
                                n_occ      = r_occ + 1'b1;
                                res_status = STS_BLOCKED;
                            end else begin
                                res_status = STS_FULL;
                            end
                        end
                        CMD_SIGNAL: begin
                            emit = 1'b1;
                            if (r_occ != '0) begin
                                n_head     = head_inc;
                                n_occ      = r_occ - 1'b1;
                                res_status = STS_WOKEN;
                                res_id     = head_id;
                            end else begin
                                if (r_count != COUNT_MAX) begin
                                    n_count = r_count + 16'd1;
                                end
                                res_status = STS_RAISED;
                            end
                        end
                        CMD_FLUSH: begin
                            n_count = 16'd0;
                        end
                        CMD_INIT: begin
                            emit       = 1'b1;
                            n_count    = i_cmd.init_count;
                            n_head     = '0;
                            n_tail     = '0;
                            n_occ      = '0;
                            res_status = STS_DONE;
                        end
                    endcase
                end
            end
            BK_FLUSH: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_occ != '0) begin
                        n_head     = head_inc;
                        n_occ      = r_occ - 1'b1;
                        res_status = STS_FLUSHED;
                        res_id     = head_id;
                        res_last   = 1'b0;
                    end else begin
                        n_head     = '0;
                        n_tail     = '0;
                        res_status = STS_DONE;
                    end
                end
            end
            default: ;
        endcase

        n_out.status        = res_status;
        n_out.woken_id      = res_id;
        n_out.current_count = n_count;
        n_out.last          = res_last;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Read port follows the next head; write-first on a collision.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_queue_mem[r_tail] <= mem_wdata;
        end
        if (mem_we && r_tail == n_head) begin
            r_rd_data <= mem_wdata;
        end else begin
            r_rd_data <= r_queue_mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= 16'd0;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/counting_semaphore_fifo.sv =====
`timescale 1ns / 1ps

// Counting semaphore with a FIFO of waiting requester ids. A two-entry command
// queue sits behind the input port, so commands are taken while the back end
// works or while a result waits at the output register. The back end executes
// one command per cycle when idle and the output register is free: wait,
// signal and init each produce one result, and flush produces one result per
// queued waiter plus a final one, one per cycle after the cycle that takes it
// while the output is not stalled, holding the back end until the final one.
// Throughput is set by the single output register (one result per cycle unless
// stalled) and the wait-queue RAM, which has one write and one registered read
// port. There is no clearing pass after reset.
module counting_semaphore_fifo #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  csf_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output csf_pkg::t_out_item o_out_data
);
    import csf_pkg::*;

    logic      cmd_valid;
    logic      cmd_pop;
    t_cmd_item cmd;

    csf_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    csf_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hw/rtl/csf_checker.sv =====
`timescale 1ns / 1ps

`include "counting_semaphore_fifo_assert.svh"

module csf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input csf_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input csf_pkg::t_out_item o_out_data
);
    import csf_pkg::*;

    logic flushed;
    logic woke;

    assign flushed = (o_out_data.status == STS_FLUSHED);
    assign woke    = flushed || (o_out_data.status == STS_WOKEN);

    // A stalled input transaction holds.
    `CSF_ASSERT_NEXT(a_in_hold, i_in_valid && !o_in_ready, i_in_valid && $stable(i_in_data))

    // A stalled result transaction holds.
    `CSF_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // Only flush wakeups are non-final.
    `CSF_ASSERT_NOW(a_last_flag, o_out_valid, flushed == !o_out_data.last)

    // Woken id is zero unless someone was woken.
    `CSF_ASSERT_NOW(a_woken_id, o_out_valid && !woke, o_out_data.woken_id == 8'd0)

    // Flushed waiters see a zero count.
    `CSF_ASSERT_NOW(a_flush_count, o_out_valid && flushed, o_out_data.current_count == 16'd0)

endmodule

bind counting_semaphore_fifo csf_checker u_csf_checker (.*);
